FILE: src/pngunf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pngunf_pkg
// Shared types and constants of the PNG RGBA scanline unfilter.
// ----------------------------------------------------------------------------
package pngunf_pkg;

  // Line store geometry
  localparam int MAX_ROW_PIXELS = 4096;
  localparam int COL_W          = $clog2(MAX_ROW_PIXELS);
  localparam int WIDTH_W        = 13;
  localparam int HEIGHT_W       = 16;
  localparam int ROW_W          = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  // Row filter codes
  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  typedef logic [31:0] pixel_t;

  typedef struct packed {
    logic [7:0] filter_type;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       row_end;
    logic       frame_end;
    logic       bad_filter;
  } out_item_t;

  // Programmed frame geometry
  typedef struct packed {
    logic [WIDTH_W-1:0]  image_width;
    logic [HEIGHT_W-1:0] image_height;
  } cfg_t;

  // Per pixel control travelling with the request into the predictor
  typedef struct packed {
    logic [7:0] filter;
    logic       col_first;
    logic       row_first;
  } pred_ctrl_t;

endpackage : pngunf_pkg
`default_nettype wire

FILE: src/pngunf_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pngunf_cfg_regs
// APB-style register file holding image width and height.
// ----------------------------------------------------------------------------
module pngunf_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [pngunf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [pngunf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [pngunf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                  cfg_pready,
  output pngunf_pkg::cfg_t                      cfg
);

  pngunf_pkg::cfg_t cfg_r;
  pngunf_pkg::cfg_t cfg_nxt;
  logic [0:0]       reg_idx;
  logic             wr_en;

  assign reg_idx    = cfg_paddr[2:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        pngunf_pkg::REG_IMAGE_WIDTH:
          cfg_nxt.image_width = cfg_pwdata[pngunf_pkg::WIDTH_W-1:0];
        pngunf_pkg::REG_IMAGE_HEIGHT:
          cfg_nxt.image_height = cfg_pwdata[pngunf_pkg::HEIGHT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= pngunf_pkg::WIDTH_W'(1);
      cfg_r.image_height <= pngunf_pkg::HEIGHT_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      pngunf_pkg::REG_IMAGE_WIDTH:
        cfg_prdata = pngunf_pkg::CFG_DATA_W'(cfg_r.image_width);
      pngunf_pkg::REG_IMAGE_HEIGHT:
        cfg_prdata = pngunf_pkg::CFG_DATA_W'(cfg_r.image_height);
      default: cfg_prdata = '0;
    endcase
  end

endmodule : pngunf_cfg_regs
`default_nettype wire

FILE: src/pngunf_line_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pngunf_line_ram
// Line store of the previous reconstructed row: one write, one registered read.
// ----------------------------------------------------------------------------
module pngunf_line_ram (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [pngunf_pkg::COL_W-1:0]  wr_addr,
  input  wire pngunf_pkg::pixel_t            wr_data,
  input  wire logic [pngunf_pkg::COL_W-1:0]  rd_addr,
  output pngunf_pkg::pixel_t                 rd_data
);

  pngunf_pkg::pixel_t mem [pngunf_pkg::MAX_ROW_PIXELS];
  pngunf_pkg::pixel_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read-before-write; same-address collisions are forwarded by the caller
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule : pngunf_line_ram
`default_nettype wire

FILE: src/pngunf_predictor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pngunf_predictor
// Per channel PNG prediction (None/Sub/Up/Average/Paeth) and reconstruction.
// ----------------------------------------------------------------------------
module pngunf_predictor (
  input  wire pngunf_pkg::pred_ctrl_t ctrl,
  input  wire pngunf_pkg::pixel_t     filt_px,
  input  wire pngunf_pkg::pixel_t     up_raw,
  input  wire pngunf_pkg::pixel_t     left_px,
  input  wire pngunf_pkg::pixel_t     upleft_px,
  output pngunf_pkg::pixel_t          recon_px,
  output pngunf_pkg::pixel_t          up_px,
  output logic                        bad
);

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic        [10:0] pa;
    logic        [10:0] pb;
    logic        [10:0] pc;
    begin
      // p - a = b - c, p - b = a - c, p - c = a + b - 2c
      da = $signed({3'b0, b}) - $signed({3'b0, c});
      db = $signed({3'b0, a}) - $signed({3'b0, c});
      dc = da + db;
      pa = da[10] ? 11'(-da) : 11'(da);
      pb = db[10] ? 11'(-db) : 11'(db);
      pc = dc[10] ? 11'(-dc) : 11'(dc);
      if (pa <= pb && pa <= pc) begin
        paeth = a;
      end else if (pb <= pc) begin
        paeth = b;
      end else begin
        paeth = c;
      end
    end
  endfunction

  pngunf_pkg::pixel_t a_px;
  pngunf_pkg::pixel_t c_px;
  logic [3:0][7:0]    pred;

  // Neighbours outside the row or frame read as zero
  assign up_px = ctrl.row_first ? '0 : up_raw;
  assign a_px  = ctrl.col_first ? '0 : left_px;
  assign c_px  = ctrl.col_first ? '0 : upleft_px;
  assign bad   = ctrl.filter > pngunf_pkg::FILT_PAETH;

  always_comb begin
    logic [8:0] sum;
    for (int k = 0; k < 4; k++) begin
      sum = {1'b0, a_px[8*k +: 8]} + {1'b0, up_px[8*k +: 8]};
      unique case (ctrl.filter)
        pngunf_pkg::FILT_NONE:  pred[k] = 8'd0;
        pngunf_pkg::FILT_SUB:   pred[k] = a_px[8*k +: 8];
        pngunf_pkg::FILT_UP:    pred[k] = up_px[8*k +: 8];
        pngunf_pkg::FILT_AVG:   pred[k] = sum[8:1];
        pngunf_pkg::FILT_PAETH: pred[k] = paeth(a_px[8*k +: 8], up_px[8*k +: 8],
                                                c_px[8*k +: 8]);
        default:                pred[k] = 8'd0;
      endcase
      recon_px[8*k +: 8] = filt_px[8*k +: 8] + pred[k];
    end
  end

endmodule : pngunf_predictor
`default_nettype wire

FILE: src/png_rgba_scanline_unfilter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// png_rgba_scanline_unfilter
// PNG row unfilter for 8-bit RGBA, one pixel per request.
//
// Input channel (in_valid/in_ready/in_data) carries filtered pixels; the
// filter byte is taken at the first pixel of every row. Output channel
// (out_valid/out_ready/out_data) returns the reconstructed pixel with
// row_end, frame_end and bad_filter marks. Geometry is programmed over the
// APB-style cfg_ port: image_width at 0x0, image_height at 0x4; write only
// while the block is idle.
// Path: stage 1 (line store read), then reconstruction into the output
// register. Throughput: one pixel per cycle while the receiver takes the
// output; the line store has one read and one write port and a same-column
// collision (one pixel rows) is forwarded. Reset clears position,
// neighbours and geometry (width 1, height 1); the line store needs no
// clearing, as its reads are masked to zero on the first row of a frame.
// A stalled receiver holds the output register; the pipeline stage behind it
// fills and then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module png_rgba_scanline_unfilter (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire pngunf_pkg::in_item_t             in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output pngunf_pkg::out_item_t                 out_data,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [pngunf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [pngunf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [pngunf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int COL_W   = pngunf_pkg::COL_W;
  localparam int WIDTH_W = pngunf_pkg::WIDTH_W;
  localparam int ROW_W   = pngunf_pkg::ROW_W;
  localparam int HGT_W   = pngunf_pkg::HEIGHT_W;

  pngunf_pkg::cfg_t cfg;

  // Register file
  pngunf_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Position state
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [7:0]       row_filter_r, row_filter_nxt;
  logic             first_row_r, first_row_nxt;

  // Stage 1 (line store read in flight)
  logic                   s1_v_r;
  pngunf_pkg::pred_ctrl_t s1_ctrl_r;
  pngunf_pkg::pixel_t     s1_px_r;
  logic [COL_W-1:0]       s1_col_r;
  logic                   s1_rend_r;
  logic                   s1_fend_r;

  // Neighbours and forwarding
  pngunf_pkg::pixel_t left_r, upleft_r;
  logic               fwd_r;
  pngunf_pkg::pixel_t fwd_data_r;

  // Output register
  logic                  out_v_r;
  pngunf_pkg::out_item_t out_data_r;

  logic                   in_fire, s1_fire;
  logic [WIDTH_W-1:0]     width_eff;
  logic [HGT_W-1:0]       height_eff;
  logic                   col_first, rend, fend;
  logic [7:0]             cur_filter;
  logic [COL_W-1:0]       rd_addr;
  pngunf_pkg::pixel_t     rd_data, up_raw, recon_px, up_px;
  logic                   bad;

  assign s1_fire  = s1_v_r & (~out_v_r | out_ready);
  assign in_ready = ~s1_v_r | s1_fire;
  assign in_fire  = in_valid & in_ready;

  // Effective geometry: zero acts as one, width saturates at line store depth
  always_comb begin
    if (cfg.image_width == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (cfg.image_width > WIDTH_W'(pngunf_pkg::MAX_ROW_PIXELS)) begin
      width_eff = WIDTH_W'(pngunf_pkg::MAX_ROW_PIXELS);
    end else begin
      width_eff = cfg.image_width;
    end
    height_eff = (cfg.image_height == '0) ? HGT_W'(1) : cfg.image_height;
  end

  // Row / frame position at accept
  always_comb begin
    col_first  = (col_r == '0);
    cur_filter = col_first ? in_data.filter_type : row_filter_r;
    rend       = ({1'b0, col_r} + (COL_W+1)'(1)) >= (COL_W+1)'(width_eff);
    fend       = rend & (({1'b0, row_r} + (ROW_W+1)'(1)) >= (ROW_W+1)'(height_eff));

    col_nxt        = col_r;
    row_nxt        = row_r;
    row_filter_nxt = row_filter_r;
    first_row_nxt  = first_row_r;
    if (in_fire) begin
      row_filter_nxt = cur_filter;
      if (rend) begin
        col_nxt = '0;
        if (fend) begin
          row_nxt       = '0;
          first_row_nxt = 1'b1;
        end else begin
          row_nxt       = row_r + ROW_W'(1);
          first_row_nxt = 1'b0;
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      row_filter_r <= '0;
      first_row_r  <= 1'b1;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      row_filter_r <= row_filter_nxt;
      first_row_r  <= first_row_nxt;
    end
  end

  // Line store: new request reads its column, a held request re-reads its own
  assign rd_addr = in_fire ? col_r : s1_col_r;

  pngunf_line_ram u_ram (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data (recon_px),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Write/read collision on the same column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= s1_fire & (s1_col_r == rd_addr);
    end
    fwd_data_r <= recon_px;
  end

  assign up_raw = fwd_r ? fwd_data_r : rd_data;

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
    if (in_fire) begin
      s1_ctrl_r.filter    <= cur_filter;
      s1_ctrl_r.col_first <= col_first;
      s1_ctrl_r.row_first <= first_row_r;
      s1_px_r             <= {in_data.in_alpha, in_data.in_blue,
                              in_data.in_green, in_data.in_red};
      s1_col_r            <= col_r;
      s1_rend_r           <= rend;
      s1_fend_r           <= fend;
    end
  end

  // Reconstruction
  pngunf_predictor u_pred (
    .ctrl      (s1_ctrl_r),
    .filt_px   (s1_px_r),
    .up_raw    (up_raw),
    .left_px   (left_r),
    .upleft_px (upleft_r),
    .recon_px  (recon_px),
    .up_px     (up_px),
    .bad       (bad)
  );

  // Neighbour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      upleft_r <= '0;
    end else if (s1_fire) begin
      left_r   <= recon_px;
      upleft_r <= up_px;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
    if (s1_fire) begin
      out_data_r.out_red    <= recon_px[7:0];
      out_data_r.out_green  <= recon_px[15:8];
      out_data_r.out_blue   <= recon_px[23:16];
      out_data_r.out_alpha  <= recon_px[31:24];
      out_data_r.row_end    <= s1_rend_r;
      out_data_r.frame_end  <= s1_fend_r;
      out_data_r.bad_filter <= bad;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule : png_rgba_scanline_unfilter
`default_nettype wire
